// ===== sv/assert_macros.svh =====
// Assertion helper macros for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert a property that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== sv/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Types and constants shared by the SHA-1 counter PRNG modules.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int unsigned HashBytes = 20;
    localparam int unsigned MaxReq    = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_ADD,
        ST_FIRST,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic       seed_we;
        logic       hash_start;
        logic       add_start;
        logic       pos_advance;
    } cmd_t;

    typedef struct packed {
        logic       hash_done;
        logic       add_done;
        logic [4:0] pos;
    } status_t;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        begin
            if (t < 7'd20)
            begin
                k = 32'h5A827999;
            end
            else if (t < 7'd40)
            begin
                k = 32'h6ED9EBA1;
            end
            else if (t < 7'd60)
            begin
                k = 32'h8F1BBCDC;
            end
            else
            begin
                k = 32'hCA62C1D6;
            end
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (t < 7'd20)
            begin
                f = (b & c) | (~b & d);
            end
            else if (t < 7'd40 || t >= 7'd60)
            begin
                f = b ^ c ^ d;
            end
            else
            begin
                f = (b & c) | (b & d) | (c & d);
            end
            return f;
        end
    endfunction

endpackage

// ===== sv/sha1_counter_prng.sv =====
// ----------------------------------------------------------------------------
// sha1_counter_prng
// Hash-based pseudo-random byte generator with a 20-byte seed state.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): mode 1 loads one seed byte, mode 0
// requests 1..64 random bytes. Output channel (out_valid/out_ready) returns
// one word per byte, last_byte marking the final one of a request; a request
// before byte 19 was seeded returns a single word with unseeded_error set.
// Bytes are read from the digest buffer; when the read position is zero
// the block runs an 80-round SHA-1 compression (one round a cycle)
// followed by a byte-serial state update. A new input word is taken only
// after the previous request's last word is registered on the output.
// Reset clears the seed state, the digest buffer, the read position and
// the seeded flag. A stalled receiver holds the output register and byte
// emission waits, but a hash and state update can still run meanwhile.
// ----------------------------------------------------------------------------
module sha1_counter_prng (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [6:0] byte_count,
    input  logic [4:0] seed_index,
    input  logic [7:0] seed_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] random_byte,
    output logic       unseeded_error,
    output logic       last_byte
);

    scp_pkg::cmd_t    cmd;
    scp_pkg::status_t status;
    logic [7:0]       buf_byte;

    scp_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .byte_count     (byte_count),
        .seed_index     (seed_index),
        .status         (status),
        .buf_byte       (buf_byte),
        .cmd            (cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .random_byte    (random_byte),
        .unseeded_error (unseeded_error),
        .last_byte      (last_byte)
    );

    scp_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .seed_index (seed_index),
        .seed_byte  (seed_byte),
        .status     (status),
        .buf_byte   (buf_byte)
    );

endmodule

// ===== sv/scp_datapath.sv =====
// ----------------------------------------------------------------------------
// scp_datapath
// Seed state, SHA-1 round engine, byte-serial state update and digest buffer.
// ----------------------------------------------------------------------------
module scp_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  scp_pkg::cmd_t    cmd,
    input  logic [4:0]       seed_index,
    input  logic [7:0]       seed_byte,
    output scp_pkg::status_t status,
    output logic [7:0]       buf_byte
);

    logic [7:0]   state_reg [scp_pkg::HashBytes];
    logic [159:0] dig_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]   rnd_reg;
    logic         hbusy_reg, hdone_reg;
    logic [4:0]   k_reg;
    logic         abusy_reg, adone_reg;
    logic [1:0]   carry_reg;     // signed carry, -2..1
    logic         changed_reg;
    logic [4:0]   pos_reg;

    logic [511:0] blk;
    logic [31:0]  w_new, t_sum;
    logic [7:0]   dig_k;
    logic [9:0]   j_sum;
    logic [7:0]   nb;

    always_comb
    begin
        blk = '0;
        for (int i = 0; i < 20; i++)
        begin
            blk[511 - 8*i -: 8] = state_reg[i];
        end
        blk[511 - 160 -: 8] = 8'h80;
        blk[7:0] = 8'hA0;
    end

    assign w_new = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                 | {31'd0, (w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31])};
    assign t_sum = {a_reg[26:0], a_reg[31:27]}
                 + scp_pkg::round_f(rnd_reg, b_reg, c_reg, d_reg)
                 + e_reg + scp_pkg::round_k(rnd_reg) + w_reg[0];

    assign dig_k = dig_reg[159 - 8*k_reg -: 8];

    // sign-extended add of state byte, digest byte and carry
    assign j_sum = {{2{state_reg[k_reg][7]}}, state_reg[k_reg]}
                 + {{2{dig_k[7]}}, dig_k}
                 + {{8{carry_reg[1]}}, carry_reg};
    assign nb = j_sum[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 20; i++)
            begin
                state_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
            a_reg       <= '0;
            b_reg       <= '0;
            c_reg       <= '0;
            d_reg       <= '0;
            e_reg       <= '0;
            dig_reg     <= '0;
            hbusy_reg   <= 1'b0;
            hdone_reg   <= 1'b0;
            abusy_reg   <= 1'b0;
            adone_reg   <= 1'b0;
            pos_reg     <= '0;
            rnd_reg     <= '0;
            k_reg       <= '0;
            carry_reg   <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            hdone_reg <= 1'b0;
            adone_reg <= 1'b0;
            if (cmd.seed_we && seed_index < 5'd20)
            begin
                state_reg[seed_index] <= seed_byte;
            end
            if (cmd.hash_start)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    w_reg[i] <= blk[511 - 32*i -: 32];
                end
                a_reg     <= 32'h67452301;
                b_reg     <= 32'hEFCDAB89;
                c_reg     <= 32'h98BADCFE;
                d_reg     <= 32'h10325476;
                e_reg     <= 32'hC3D2E1F0;
                rnd_reg   <= '0;
                hbusy_reg <= 1'b1;
            end
            else if (hbusy_reg)
            begin
                if (rnd_reg == 7'd80)
                begin
                    dig_reg   <= {a_reg + 32'h67452301, b_reg + 32'hEFCDAB89,
                                  c_reg + 32'h98BADCFE, d_reg + 32'h10325476,
                                  e_reg + 32'hC3D2E1F0};
                    hbusy_reg <= 1'b0;
                    hdone_reg <= 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= w_new;
                    e_reg     <= d_reg;
                    d_reg     <= c_reg;
                    c_reg     <= {b_reg[1:0], b_reg[31:2]};
                    b_reg     <= a_reg;
                    a_reg     <= t_sum;
                    rnd_reg   <= rnd_reg + 7'd1;
                end
            end
            if (cmd.add_start)
            begin
                k_reg       <= '0;
                carry_reg   <= 2'd1;
                changed_reg <= 1'b0;
                abusy_reg   <= 1'b1;
            end
            else if (abusy_reg)
            begin
                if (k_reg == 5'd20)
                begin
                    if (!changed_reg)
                    begin
                        state_reg[0] <= state_reg[0] + 8'd1;
                    end
                    abusy_reg <= 1'b0;
                    adone_reg <= 1'b1;
                end
                else
                begin
                    state_reg[k_reg] <= nb;
                    if (nb != state_reg[k_reg])
                    begin
                        changed_reg <= 1'b1;
                    end
                    carry_reg <= j_sum[9:8];
                    k_reg     <= k_reg + 5'd1;
                end
            end
            if (cmd.pos_advance)
            begin
                pos_reg <= (pos_reg == 5'd19) ? 5'd0 : pos_reg + 5'd1;
            end
        end
    end

    assign status.hash_done = hdone_reg;
    assign status.add_done  = adone_reg;
    assign status.pos       = pos_reg;
    assign buf_byte         = dig_reg[159 - 8*pos_reg -: 8];

endmodule

// ===== sv/scp_ctrl.sv =====
// ----------------------------------------------------------------------------
// scp_ctrl
// Request sequencer: accepts words, starts hash and update, emits bytes.
// ----------------------------------------------------------------------------
module scp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             mode,
    input  logic [6:0]       byte_count,
    input  logic [4:0]       seed_index,
    input  scp_pkg::status_t status,
    input  logic [7:0]       buf_byte,
    output scp_pkg::cmd_t    cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       random_byte,
    output logic             unseeded_error,
    output logic             last_byte
);

    scp_pkg::state_t state_reg, state_next;
    logic [6:0] left_reg, left_next;
    logic       seeded_reg;
    logic       ov_reg, ov_next;
    logic [7:0] rb_reg, rb_next;
    logic       err_reg, err_next, last_reg, last_next;
    logic       fire;
    logic [6:0] n_sat;

    assign fire  = in_valid && in_ready;
    assign n_sat = (byte_count > 7'd64) ? 7'd64 : byte_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= scp_pkg::ST_IDLE;
            left_reg   <= '0;
            seeded_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            ov_reg    <= ov_next;
            if (fire && mode && seed_index == 5'd19)
            begin
                seeded_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rb_reg   <= rb_next;
        err_reg  <= err_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        ov_next    = ov_reg && !out_ready;
        rb_next    = rb_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            scp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode)
                    begin
                        cmd.seed_we = 1'b1;
                    end
                    else if (!seeded_reg)
                    begin
                        state_next = scp_pkg::ST_ERR;
                    end
                    else if (n_sat != 7'd0)
                    begin
                        left_next  = n_sat;
                        state_next = scp_pkg::ST_EMIT;
                    end
                end
            end
            scp_pkg::ST_ERR:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    rb_next    = '0;
                    err_next   = 1'b1;
                    last_next  = 1'b1;
                    state_next = scp_pkg::ST_IDLE;
                end
            end
            scp_pkg::ST_EMIT:
            begin
                if (status.pos == 5'd0)
                begin
                    cmd.hash_start = 1'b1;
                    state_next     = scp_pkg::ST_HASH;
                end
                else if (!ov_reg || out_ready)
                begin
                    ov_next         = 1'b1;
                    rb_next         = buf_byte;
                    err_next        = 1'b0;
                    last_next       = (left_reg == 7'd1);
                    cmd.pos_advance = 1'b1;
                    left_next       = left_reg - 7'd1;
                    if (left_reg == 7'd1)
                    begin
                        state_next = scp_pkg::ST_IDLE;
                    end
                end
            end
            scp_pkg::ST_HASH:
            begin
                if (status.hash_done)
                begin
                    cmd.add_start = 1'b1;
                    state_next    = scp_pkg::ST_ADD;
                end
            end
            scp_pkg::ST_ADD:
            begin
                if (status.add_done)
                begin
                    state_next = scp_pkg::ST_FIRST;
                end
            end
            scp_pkg::ST_FIRST:
            begin
                // emit byte 0 of the fresh digest, then resume
                if (!ov_reg || out_ready)
                begin
                    ov_next         = 1'b1;
                    rb_next         = buf_byte;
                    err_next        = 1'b0;
                    last_next       = (left_reg == 7'd1);
                    cmd.pos_advance = 1'b1;
                    left_next       = left_reg - 7'd1;
                    state_next      = (left_reg == 7'd1) ? scp_pkg::ST_IDLE
                                                         : scp_pkg::ST_EMIT;
                end
            end
            default:
            begin
                state_next = scp_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid      = ov_reg;
    assign random_byte    = rb_reg;
    assign unseeded_error = err_reg;
    assign last_byte      = last_reg;

endmodule

// ===== sv/scp_checker.sv =====
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks for the SHA-1 counter PRNG.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] random_byte,
    input logic       unseeded_error,
    input logic       last_byte
);

    `ASSERT_IMPL(a_err_is_last, clk, rst_n, out_valid && unseeded_error |-> last_byte,
                 "error word without last mark")
    `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && unseeded_error |-> random_byte == 8'd0,
                 "error word with nonzero byte")
    `ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(random_byte),
                 "stalled output word changed")
    `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind sha1_counter_prng scp_checker u_scp_checker (.*);

// ===== tb/tb_sha1_counter_prng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_counter_prng
// Drives seed loads and byte requests into the hash-based byte generator,
// predicts every output word with a local SHA-1 and state-update model, and
// compares each word in order against the prediction.
// ----------------------------------------------------------------------------
module tb_sha1_counter_prng;

    localparam int unsigned NumBytes = 20;
    localparam int unsigned MaxCount = 64;

    typedef struct packed {
        logic [7:0] value;
        logic       err;
        logic       last;
    } word_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       mode;
    logic [6:0] byte_count;
    logic [4:0] seed_index;
    logic [7:0] seed_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] random_byte;
    logic       unseeded_error;
    logic       last_byte;

    logic [7:0] gen_state [NumBytes];
    logic [7:0] gen_digest [NumBytes];
    logic [4:0] gen_pos;
    logic       gen_seeded;

    word_t      pending_words [$];
    int         error_count;
    int         out_wait;

    sha1_counter_prng dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .byte_count(byte_count), .seed_index(seed_index),
        .seed_byte(seed_byte), .out_valid(out_valid), .out_ready(out_ready),
        .random_byte(random_byte), .unseeded_error(unseeded_error),
        .last_byte(last_byte)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // SHA-1 of the 20 state bytes into the digest buffer
    task automatic hash_state();
        logic [7:0]  blk [64];
        logic [31:0] w [80];
        logic [31:0] h [5];
        logic [31:0] a, b, c, d, e, f, k, t;
        begin
            h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
            h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
            for (int i = 0; i < 64; i++) blk[i] = 8'h00;
            for (int i = 0; i < NumBytes; i++) blk[i] = gen_state[i];
            blk[20] = 8'h80;
            blk[63] = 8'hA0;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 80; i++)
                w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
            for (int i = 0; i < 80; i++)
            begin
                if (i < 20)
                begin
                    f = (b & c) | (~b & d); k = 32'h5A827999;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d; k = 32'h6ED9EBA1;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
                end
                else
                begin
                    f = b ^ c ^ d; k = 32'hCA62C1D6;
                end
                t = rol(a, 5) + f + e + k + w[i];
                e = d; d = c; c = rol(b, 30); b = a; a = t;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
            for (int i = 0; i < 5; i++)
                {gen_digest[4*i], gen_digest[4*i+1], gen_digest[4*i+2],
                 gen_digest[4*i+3]} = h[i];
        end
    endtask

    // signed byte-wise add of the digest into the state, carry-in 1; byte 0 is bumped if no byte changed
    task automatic advance_state();
        int  carry;
        int  j;
        bit  changed;
        logic [7:0] nb;
        begin
            carry = 1;
            changed = 0;
            for (int i = 0; i < NumBytes; i++)
            begin
                j = $signed(gen_state[i]) + $signed(gen_digest[i]) + carry;
                nb = j[7:0];
                if (nb != gen_state[i]) changed = 1;
                gen_state[i] = nb;
                carry = j >>> 8;
            end
            if (!changed) gen_state[0] = gen_state[0] + 8'd1;
        end
    endtask

    task automatic predict_words(input logic m, input logic [6:0] cnt,
                                 input logic [4:0] idx, input logic [7:0] val);
        int n;
        begin
            if (m)
            begin
                if (idx < NumBytes)
                begin
                    gen_state[idx] = val;
                    if (idx == NumBytes - 1) gen_seeded = 1;
                end
            end
            else if (!gen_seeded)
                pending_words.push_back('{8'h00, 1'b1, 1'b1});
            else
            begin
                n = (cnt > MaxCount) ? MaxCount : cnt;
                for (int r = 0; r < n; r++)
                begin
                    if (gen_pos == 0)
                    begin
                        hash_state();
                        advance_state();
                    end
                    pending_words.push_back('{gen_digest[gen_pos], 1'b0, r == n - 1});
                    gen_pos = (gen_pos == NumBytes - 1) ? 5'd0 : gen_pos + 5'd1;
                end
            end
        end
    endtask

    task automatic send_word(input logic m, input logic [6:0] cnt,
                             input logic [4:0] idx, input logic [7:0] val);
        int gap;
        begin
            gap = $urandom_range(0, 9);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid   <= 1'b1;
            mode       <= m;
            byte_count <= cnt;
            seed_index <= idx;
            seed_byte  <= val;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            predict_words(m, cnt, idx, val);
        end
    endtask

    task automatic send_seed(input logic [4:0] idx, input logic [7:0] val);
        send_word(1'b1, 7'($urandom), idx, val);
    endtask

    task automatic send_request(input logic [6:0] cnt);
        send_word(1'b0, cnt, 5'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    task automatic test_unseeded();
        begin
            send_request(7'd1);
            send_request(7'd0);
            send_request(7'd127);
            for (int i = 0; i < 19; i++) send_seed(5'(i), 8'($urandom));
            send_seed(5'd25, 8'hFF);  // out of range index, ignored
            send_request(7'd5);
        end
    endtask

    task automatic test_directed();
        begin
            // zero state hits the no-change increment path rarely; try extremes
            for (int i = 0; i < NumBytes; i++) send_seed(5'(i), 8'h00);
            send_request(7'd1);
            send_request(7'd0);
            send_request(7'd64);
            send_request(7'd100);
            send_seed(5'd0, 8'hFF);
            send_seed(5'd31, 8'h00);
            send_request(7'd19);
        end
    endtask

    task automatic test_random();
        int kind;
        begin
            for (int n = 0; n < 240; n++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 6)
                    send_request(($urandom_range(0, 7) == 0) ? 7'($urandom_range(1, 64))
                                                               : 7'($urandom_range(1, 12)));
                else if (kind < 9)
                    send_seed(5'($urandom_range(0, 19)), 8'($urandom));
                else
                    send_word(1'($urandom), 7'($urandom), 5'($urandom), 8'($urandom));
                if (n == 120) wait_drained();
            end
        end
    endtask

    // check each output word against the oldest prediction
    always @(posedge clk)
    begin
        word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word random_byte=%0h", random_byte);
                error_count++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (random_byte !== exp_w.value)
                begin
                    $error("random_byte exp %0h got %0h", exp_w.value, random_byte);
                    error_count++;
                end
                if (unseeded_error !== exp_w.err)
                begin
                    $error("unseeded_error exp %0b got %0b", exp_w.err, unseeded_error);
                    error_count++;
                end
                if (last_byte !== exp_w.last)
                begin
                    $error("last_byte exp %0b got %0b", exp_w.last, last_byte);
                    error_count++;
                end
            end
        end
        if (rst_n)
        begin
            // draw a fresh stall for each word taken
            if (out_valid && out_ready)
                out_wait = $urandom_range(0, 9);
            else if (out_wait > 0)
                out_wait--;
            out_ready <= (out_wait == 0);
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        mode = 0;
        byte_count = 0;
        seed_index = 0;
        seed_byte = 0;
        error_count = 0;
        out_wait = 0;
        gen_pos = 0;
        gen_seeded = 0;
        for (int i = 0; i < NumBytes; i++)
        begin
            gen_state[i] = 0;
            gen_digest[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unseeded();
        test_directed();
        test_random();
        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0 && pending_words.size() == 0)
            $display("tb_sha1_counter_prng: clean");
        else
            $display("tb_sha1_counter_prng: errors");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("tb_sha1_counter_prng: errors");
        $finish;
    end

endmodule
